### hdl/keypad_pin_lock_controller_assert.svh
// assertion macros for the keypad pin lock controller
`ifndef KEYPAD_PIN_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_PIN_LOCK_CONTROLLER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define KPLC_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("kplc check failed");

// condition must hold in the cycle after the trigger
`define KPLC_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("kplc check failed");

`endif

### hdl/kplc_pkg.sv
// shared types and constants for the keypad pin lock controller
`default_nettype none
package kplc_pkg;

  localparam int PIN_DIGITS_DEF = 4;
  localparam int COUNT_W = 3;
  localparam int APP_W = 16;

  localparam logic [2:0] CMD_KEY      = 3'd0;
  localparam logic [2:0] CMD_ENABLE   = 3'd1;
  localparam logic [2:0] CMD_DISABLE  = 3'd2;
  localparam logic [2:0] CMD_SETTINGS = 3'd3;
  localparam logic [2:0] CMD_BOOT     = 3'd4;
  localparam logic [2:0] CMD_CANCEL   = 3'd5;

  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_BACKSPACE  = 4'd10;
  localparam logic [3:0] KEY_CLEAR      = 4'd11;

  localparam logic LOCK_DEVICE   = 1'b0;
  localparam logic LOCK_SETTINGS = 1'b1;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_SET,
    MODE_UNLOCK,
    MODE_DISABLE
  } mode_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [3:0]       key_code;
    logic             lock_kind;
    logic [APP_W-1:0] app_ident;
  } in_item_t;

  typedef struct packed {
    logic               prompt_open;
    logic [COUNT_W-1:0] digits_entered;
    logic               wrong_pin;
    logic               answered;
    logic               outcome_ok;
    logic               launch_valid;
    logic [APP_W-1:0]   launch_app;
    logic               launch_blocked;
    logic               device_lock_on;
    logic               settings_lock_on;
    logic               device_open;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/kplc_engine.sv
// lock state registers and the combinational next-state update for each event
`default_nettype none
module kplc_engine
  import kplc_pkg::*;
#(
  parameter int PIN_DIGITS = PIN_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  typedef logic [PIN_DIGITS-1:0][3:0] pin_t;

  pin_t               entry_digits, entry_digits_next;
  logic [COUNT_W-1:0] entry_count, entry_count_next;
  mode_t              prompt_mode, prompt_mode_next;
  logic               prompt_lock, prompt_lock_next;
  logic               cancel_allowed, cancel_allowed_next;
  logic [APP_W-1:0]   pending_app, pending_app_next;
  logic               pending_app_valid, pending_app_valid_next;
  pin_t               stored_pin [2];
  logic [1:0]         stored_pin_ok, stored_pin_ok_next;
  logic [1:0]         lock_enabled, lock_enabled_next;
  logic               dev_unlocked, dev_unlocked_next;

  logic               active;
  pin_t               digits_typed;
  logic               pin_match;
  logic               pin_we;
  logic               do_finish;
  logic               finish_ok;
  logic               want_on;
  logic               r_wrong, r_answered, r_ok, r_launch, r_blocked;
  logic [APP_W-1:0]   r_app;

  assign active  = (prompt_mode != MODE_NONE);
  assign want_on = (item.cmd == CMD_ENABLE);

  // entry with the incoming digit placed at the current position
  always_comb begin
    for (int i = 0; i < PIN_DIGITS; i++) begin
      digits_typed[i] = (entry_count == COUNT_W'(i)) ? item.key_code : entry_digits[i];
    end
  end

  assign pin_match = stored_pin_ok[prompt_lock] &&
                     (stored_pin[prompt_lock] == digits_typed);

  // next state
  always_comb begin
    entry_digits_next      = entry_digits;
    entry_count_next       = entry_count;
    prompt_mode_next       = prompt_mode;
    prompt_lock_next       = prompt_lock;
    cancel_allowed_next    = cancel_allowed;
    pending_app_next       = pending_app;
    pending_app_valid_next = pending_app_valid;
    stored_pin_ok_next     = stored_pin_ok;
    lock_enabled_next      = lock_enabled;
    dev_unlocked_next      = dev_unlocked;
    pin_we     = 1'b0;
    do_finish  = 1'b0;
    finish_ok  = 1'b0;
    r_wrong    = 1'b0;
    r_answered = 1'b0;
    r_ok       = 1'b0;
    r_launch   = 1'b0;
    r_blocked  = 1'b0;
    r_app      = '0;

    unique case (item.cmd)
      CMD_KEY: begin
        if (active) begin
          if (item.key_code == KEY_BACKSPACE) begin
            if (entry_count != '0) begin
              entry_count_next = entry_count - COUNT_W'(1);
              for (int i = 0; i < PIN_DIGITS; i++) begin
                if (COUNT_W'(i) == entry_count - COUNT_W'(1)) begin
                  entry_digits_next[i] = '0;
                end
              end
            end
          end else if (item.key_code == KEY_CLEAR) begin
            entry_digits_next = '0;
            entry_count_next  = '0;
          end else if (item.key_code <= KEY_LAST_DIGIT) begin
            if (entry_count == COUNT_W'(PIN_DIGITS - 1)) begin
              unique case (prompt_mode)
                MODE_SET: begin
                  pin_we                          = 1'b1;
                  stored_pin_ok_next[prompt_lock] = 1'b1;
                  lock_enabled_next[prompt_lock]  = 1'b1;
                  finish_ok                       = 1'b1;
                end
                MODE_UNLOCK, MODE_DISABLE: begin
                  if (!pin_match) begin
                    r_wrong           = 1'b1;
                    entry_digits_next = '0;
                    entry_count_next  = '0;
                  end else begin
                    if (prompt_mode == MODE_DISABLE) begin
                      stored_pin_ok_next[prompt_lock] = 1'b0;
                      lock_enabled_next[prompt_lock]  = 1'b0;
                    end
                    finish_ok = 1'b1;
                  end
                end
                default: ;
              endcase
              if (finish_ok) begin
                do_finish = 1'b1;
                if (prompt_lock == LOCK_DEVICE) begin
                  dev_unlocked_next = 1'b1;
                end
              end
            end else begin
              entry_digits_next = digits_typed;
              entry_count_next  = entry_count + COUNT_W'(1);
            end
          end
        end
      end
      CMD_ENABLE, CMD_DISABLE: begin
        if (lock_enabled[item.lock_kind] == want_on) begin
          r_answered = 1'b1;
          r_ok       = 1'b1;
        end else if (active) begin
          r_answered = 1'b1;
        end else begin
          prompt_mode_next       = want_on ? MODE_SET : MODE_DISABLE;
          prompt_lock_next       = item.lock_kind;
          cancel_allowed_next    = 1'b1;
          pending_app_valid_next = 1'b0;
          pending_app_next       = '0;
          entry_digits_next      = '0;
          entry_count_next       = '0;
        end
      end
      CMD_SETTINGS: begin
        if (lock_enabled[LOCK_SETTINGS]) begin
          r_blocked = 1'b1;
          if (!((lock_enabled[LOCK_DEVICE] && !dev_unlocked) || active)) begin
            prompt_mode_next       = MODE_UNLOCK;
            prompt_lock_next       = LOCK_SETTINGS;
            cancel_allowed_next    = 1'b1;
            pending_app_valid_next = 1'b1;
            pending_app_next       = item.app_ident;
            entry_digits_next      = '0;
            entry_count_next       = '0;
          end
        end
      end
      CMD_BOOT: begin
        if (lock_enabled[LOCK_DEVICE] && !dev_unlocked && !active) begin
          prompt_mode_next       = MODE_UNLOCK;
          prompt_lock_next       = LOCK_DEVICE;
          cancel_allowed_next    = 1'b0;
          pending_app_valid_next = 1'b0;
          pending_app_next       = '0;
          entry_digits_next      = '0;
          entry_count_next       = '0;
        end
      end
      CMD_CANCEL: begin
        if (active && cancel_allowed) begin
          do_finish = 1'b1;
        end
      end
      default: ;
    endcase

    // close the prompt and answer the requester
    if (do_finish) begin
      if (prompt_mode == MODE_UNLOCK && finish_ok && prompt_lock == LOCK_SETTINGS &&
          pending_app_valid) begin
        r_launch = 1'b1;
        r_app    = pending_app;
      end
      if (prompt_mode == MODE_SET || prompt_mode == MODE_DISABLE) begin
        r_answered = 1'b1;
        r_ok       = finish_ok;
      end
      entry_digits_next      = '0;
      entry_count_next       = '0;
      prompt_mode_next       = MODE_NONE;
      pending_app_next       = '0;
      pending_app_valid_next = 1'b0;
      cancel_allowed_next    = 1'b1;
    end
  end

  // result item
  always_comb begin
    result.prompt_open      = (prompt_mode_next != MODE_NONE);
    result.digits_entered   = entry_count_next;
    result.wrong_pin        = r_wrong;
    result.answered         = r_answered;
    result.outcome_ok       = r_ok;
    result.launch_valid     = r_launch;
    result.launch_app       = r_app;
    result.launch_blocked   = r_blocked;
    result.device_lock_on   = lock_enabled_next[LOCK_DEVICE];
    result.settings_lock_on = lock_enabled_next[LOCK_SETTINGS];
    result.device_open      = dev_unlocked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_digits      <= '0;
      entry_count       <= '0;
      prompt_mode       <= MODE_NONE;
      prompt_lock       <= LOCK_DEVICE;
      cancel_allowed    <= 1'b1;
      pending_app       <= '0;
      pending_app_valid <= 1'b0;
      stored_pin_ok     <= '0;
      lock_enabled      <= '0;
      dev_unlocked      <= 1'b1;
    end else if (fire) begin
      entry_digits      <= entry_digits_next;
      entry_count       <= entry_count_next;
      prompt_mode       <= prompt_mode_next;
      prompt_lock       <= prompt_lock_next;
      cancel_allowed    <= cancel_allowed_next;
      pending_app       <= pending_app_next;
      pending_app_valid <= pending_app_valid_next;
      stored_pin_ok     <= stored_pin_ok_next;
      lock_enabled      <= lock_enabled_next;
      dev_unlocked      <= dev_unlocked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pin_we) begin
      stored_pin[prompt_lock] <= digits_typed;
    end
  end

endmodule
`default_nettype wire

### hdl/keypad_pin_lock_controller.sv
// top level of the keypad pin lock controller
`default_nettype none
`include "keypad_pin_lock_controller_assert.svh"
// Takes one event item per cycle when not stalled and returns exactly one result
// item for each. An accepted item sits in an input register, the lock state is
// updated from it as it advances, and the result lands in an output register. The
// lock state feeds back into the update of the next item, so consecutive items need
// no spacing. The input side stalls only while the input register is full and the
// output item is stalled.
module keypad_pin_lock_controller
  import kplc_pkg::*;
#(
  parameter int PIN_DIGITS = PIN_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      held_valid;
  in_item_t  held_item;
  logic      advance;
  out_item_t step_result;

  assign advance  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && out_valid && out_stall;

  kplc_engine #(
    .PIN_DIGITS(PIN_DIGITS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (held_item),
    .result(step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        held_valid <= in_valid;
      end
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_data;
    end
    if (advance) begin
      out_data <= step_result;
    end
  end

  `KPLC_ASSERT_NOW(a_count_bound, out_valid,
                   4'(out_data.digits_entered) < 4'(PIN_DIGITS))
  `KPLC_ASSERT_NOW(a_launch_closes, out_valid && out_data.launch_valid,
                   !out_data.prompt_open && !out_data.answered)
  `KPLC_ASSERT_NOW(a_wrong_clears, out_valid && out_data.wrong_pin,
                   out_data.prompt_open && out_data.digits_entered == '0)
  `KPLC_ASSERT_NEXT(a_held_kept, held_valid && out_valid && out_stall, held_valid)

endmodule
`default_nettype wire

### test/tb_keypad_pin_lock_controller.sv
`timescale 1ns / 1ps
// testbench for the keypad pin lock controller: directed and random event streams checked per item
module tb_keypad_pin_lock_controller;
  import kplc_pkg::*;

  localparam int PIN_LEN = PIN_DIGITS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [3:0] KEY_UNUSED = 4'd12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // lock state as the testbench sees it
  logic [PIN_LEN-1:0][3:0] entry;
  logic [2:0] entry_cnt;
  mode_t mode;
  logic plock;
  logic can_cancel;
  logic [APP_W-1:0] pend_app;
  logic pend_valid;
  logic [PIN_LEN-1:0][3:0] pin_store [2];
  logic pin_ok [2];
  logic lock_on [2];
  logic dev_open;

  out_item_t resp;
  out_item_t want_result;
  out_item_t lock_results_due [$];

  keypad_pin_lock_controller uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_item_t make_item(input logic [2:0] cmd, input logic [3:0] key,
                                         input logic kind, input logic [APP_W-1:0] app);
    in_item_t it;
    it.cmd = cmd;
    it.key_code = key;
    it.lock_kind = kind;
    it.app_ident = app;
    return it;
  endfunction

  function automatic void clear_entry();
    entry = '0;
    entry_cnt = '0;
  endfunction

  function automatic void start_prompt(input mode_t m, input logic lk, input logic cc,
                                       input logic av, input logic [APP_W-1:0] app);
    mode = m;
    plock = lk;
    can_cancel = cc;
    pend_valid = av;
    pend_app = av ? app : '0;
    clear_entry();
  endfunction

  function automatic void close_prompt(input logic ok);
    if (mode == MODE_UNLOCK && ok && plock == LOCK_SETTINGS && pend_valid) begin
      resp.launch_valid = 1'b1;
      resp.launch_app = pend_app;
    end
    if (mode == MODE_SET || mode == MODE_DISABLE) begin
      resp.answered = 1'b1;
      resp.outcome_ok = ok;
    end
    clear_entry();
    mode = MODE_NONE;
    pend_app = '0;
    pend_valid = 1'b0;
    can_cancel = 1'b1;
  endfunction

  // advances the lock state by one event and returns the result it causes
  function automatic out_item_t lock_response(input in_item_t ev);
    logic active;
    logic want_on;
    logic lk;
    resp = '0;
    active = (mode != MODE_NONE);
    case (ev.cmd)
      CMD_KEY: begin
        if (active && ev.key_code <= KEY_CLEAR) begin
          if (ev.key_code == KEY_BACKSPACE) begin
            if (entry_cnt != 0) begin
              entry_cnt = entry_cnt - 3'd1;
              entry[entry_cnt] = 4'd0;
            end
          end else if (ev.key_code == KEY_CLEAR) begin
            clear_entry();
          end else if (entry_cnt < PIN_LEN) begin
            entry[entry_cnt] = ev.key_code;
            entry_cnt = entry_cnt + 3'd1;
            if (entry_cnt == PIN_LEN) begin
              lk = plock;
              if (mode == MODE_SET) begin
                pin_store[lk] = entry;
                pin_ok[lk] = 1'b1;
                lock_on[lk] = 1'b1;
              end else if (!pin_ok[lk] || pin_store[lk] != entry) begin
                resp.wrong_pin = 1'b1;
                clear_entry();
              end else if (mode == MODE_DISABLE) begin
                pin_ok[lk] = 1'b0;
                lock_on[lk] = 1'b0;
              end
              if (!resp.wrong_pin) begin
                if (lk == LOCK_DEVICE) dev_open = 1'b1;
                close_prompt(1'b1);
              end
            end
          end
        end
      end
      CMD_ENABLE, CMD_DISABLE: begin
        want_on = (ev.cmd == CMD_ENABLE);
        if (lock_on[ev.lock_kind] == want_on) begin
          resp.answered = 1'b1;
          resp.outcome_ok = 1'b1;
        end else if (active) begin
          resp.answered = 1'b1;
        end else begin
          start_prompt(want_on ? MODE_SET : MODE_DISABLE, ev.lock_kind, 1'b1, 1'b0, '0);
        end
      end
      CMD_SETTINGS: begin
        if (lock_on[LOCK_SETTINGS]) begin
          resp.launch_blocked = 1'b1;
          if (!((lock_on[LOCK_DEVICE] && !dev_open) || active))
            start_prompt(MODE_UNLOCK, LOCK_SETTINGS, 1'b1, 1'b1, ev.app_ident);
        end
      end
      CMD_BOOT: begin
        if (lock_on[LOCK_DEVICE] && !dev_open && !active)
          start_prompt(MODE_UNLOCK, LOCK_DEVICE, 1'b0, 1'b0, '0);
      end
      CMD_CANCEL: begin
        if (active && can_cancel) close_prompt(1'b0);
      end
      default: ;
    endcase
    resp.prompt_open = (mode != MODE_NONE);
    resp.digits_entered = entry_cnt;
    resp.device_lock_on = lock_on[LOCK_DEVICE];
    resp.settings_lock_on = lock_on[LOCK_SETTINGS];
    resp.device_open = dev_open;
    return resp;
  endfunction

  task automatic send_event(input in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lock_results_due.push_back(lock_response(item));
  endtask

  task automatic type_code(input logic [15:0] code);
    int i;
    for (i = 3; i >= 0; i--)
      send_event(make_item(CMD_KEY, code[4*i +: 4], LOCK_DEVICE, '0));
  endtask

  // works the open prompt through one full code, with edits, noise and the odd cancel
  task automatic enter_code(input bit right, output int sent);
    logic [PIN_LEN-1:0][3:0] code;
    int i;
    int pos;
    int pick;
    bit finished;
    sent = 0;
    finished = 0;
    for (i = 0; i < PIN_LEN; i++) code[i] = 4'($urandom_range(9));
    if (right && mode != MODE_NONE && pin_ok[plock]) code = pin_store[plock];
    while (!finished && mode != MODE_NONE) begin
      pos = int'(entry_cnt);
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_event(make_item(CMD_CANCEL, 4'($urandom), 1'($urandom), 16'($urandom)));
      end else if (pick < 7) begin
        send_event(make_item(CMD_KEY, 4'($urandom_range(12, 15)), 1'($urandom),
                             16'($urandom)));
      end else if (pick < 9) begin
        send_event(make_item(3'($urandom_range(6, 7)), 4'($urandom), 1'($urandom),
                             16'($urandom)));
      end else if (pick < 11) begin
        send_event(make_item(CMD_SETTINGS, 4'($urandom), 1'($urandom), 16'($urandom)));
      end else if (pick < 15) begin
        send_event(make_item(CMD_KEY, KEY_BACKSPACE, 1'($urandom), 16'($urandom)));
      end else if (pick < 17) begin
        send_event(make_item(CMD_KEY, KEY_CLEAR, 1'($urandom), 16'($urandom)));
      end else begin
        send_event(make_item(CMD_KEY, code[pos], 1'($urandom), 16'($urandom)));
        finished = (pos == PIN_LEN - 1);
      end
      sent++;
    end
  endtask

  task automatic test_directed();
    send_event(make_item(CMD_KEY, 4'd5, LOCK_DEVICE, '0));
    send_event(make_item(CMD_UNUSED, 4'd0, LOCK_DEVICE, '0));
    send_event(make_item(CMD_CANCEL, 4'd0, LOCK_DEVICE, '0));
    send_event(make_item(CMD_BOOT, 4'd0, LOCK_DEVICE, '0));
    send_event(make_item(CMD_SETTINGS, 4'd0, LOCK_DEVICE, 16'hFFFF));
    send_event(make_item(CMD_DISABLE, 4'd0, LOCK_SETTINGS, '0));
    send_event(make_item(CMD_ENABLE, 4'd0, LOCK_SETTINGS, '0));
    send_event(make_item(CMD_ENABLE, 4'd0, LOCK_DEVICE, '0));
    send_event(make_item(CMD_KEY, KEY_BACKSPACE, LOCK_DEVICE, '0));
    send_event(make_item(CMD_KEY, KEY_UNUSED, LOCK_DEVICE, '0));
    send_event(make_item(CMD_KEY, KEY_LAST_DIGIT, LOCK_DEVICE, '0));
    send_event(make_item(CMD_KEY, KEY_CLEAR, LOCK_DEVICE, '0));
    type_code(16'h9009);
    send_event(make_item(CMD_SETTINGS, 4'd0, LOCK_DEVICE, 16'hFFFF));
    send_event(make_item(CMD_SETTINGS, 4'd0, LOCK_DEVICE, 16'h1234));
    type_code(16'h9009);
    send_event(make_item(CMD_DISABLE, 4'd0, LOCK_SETTINGS, '0));
    type_code(16'h0000);
    send_event(make_item(CMD_CANCEL, 4'd0, LOCK_DEVICE, '0));
  endtask

  task automatic test_random(input int n);
    int done_items;
    int pick;
    int sent;
    done_items = 0;
    while (done_items < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_event(make_item(CMD_ENABLE, 4'($urandom), 1'($urandom), 16'($urandom)));
        enter_code($urandom_range(99) < 70, sent);
        done_items += 1 + sent;
      end else if (pick < 50) begin
        send_event(make_item(CMD_DISABLE, 4'($urandom), 1'($urandom), 16'($urandom)));
        enter_code($urandom_range(99) < 75, sent);
        done_items += 1 + sent;
      end else if (pick < 72) begin
        send_event(make_item(CMD_SETTINGS, 4'($urandom), 1'($urandom), 16'($urandom)));
        enter_code($urandom_range(99) < 70, sent);
        done_items += 1 + sent;
      end else if (pick < 77) begin
        send_event(make_item(CMD_BOOT, 4'($urandom), 1'($urandom), 16'($urandom)));
        enter_code(1'b1, sent);
        done_items += 1 + sent;
      end else if (pick < 85) begin
        send_event(make_item(CMD_CANCEL, 4'($urandom), 1'($urandom), 16'($urandom)));
        done_items++;
      end else begin
        send_event(make_item(3'($urandom), 4'($urandom), 1'($urandom), 16'($urandom)));
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) $display("mismatch at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (lock_results_due.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want_result = lock_results_due.pop_front();
        check_field("prompt_open", 16'(out_data.prompt_open),
                    16'(want_result.prompt_open));
        check_field("digits_entered", 16'(out_data.digits_entered),
                    16'(want_result.digits_entered));
        check_field("wrong_pin", 16'(out_data.wrong_pin), 16'(want_result.wrong_pin));
        check_field("answered", 16'(out_data.answered), 16'(want_result.answered));
        check_field("outcome_ok", 16'(out_data.outcome_ok), 16'(want_result.outcome_ok));
        check_field("launch_valid", 16'(out_data.launch_valid),
                    16'(want_result.launch_valid));
        check_field("launch_app", out_data.launch_app, want_result.launch_app);
        check_field("launch_blocked", 16'(out_data.launch_blocked),
                    16'(want_result.launch_blocked));
        check_field("device_lock_on", 16'(out_data.device_lock_on),
                    16'(want_result.device_lock_on));
        check_field("settings_lock_on", 16'(out_data.settings_lock_on),
                    16'(want_result.settings_lock_on));
        check_field("device_open", 16'(out_data.device_open),
                    16'(want_result.device_open));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_keypad_pin_lock_controller: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_entry();
    mode = MODE_NONE;
    plock = LOCK_DEVICE;
    can_cancel = 1'b1;
    pend_app = '0;
    pend_valid = 1'b0;
    pin_ok[0] = 1'b0;
    pin_ok[1] = 1'b0;
    lock_on[0] = 1'b0;
    lock_on[1] = 1'b0;
    dev_open = 1'b1;
    send_idle_pct = 26;
    recv_stall_pct = 61;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(270);
    send_idle_pct = 61;
    recv_stall_pct = 26;
    test_random(270);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(270);
    in_valid <= 1'b0;
    while (lock_results_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("tb_keypad_pin_lock_controller: PASS");
    end else begin
      $display("tb_keypad_pin_lock_controller: FAIL");
    end
    $finish;
  end

endmodule

### keypad_pin_lock_controller.f
+incdir+hdl
hdl/kplc_pkg.sv
hdl/kplc_engine.sv
hdl/keypad_pin_lock_controller.sv
test/tb_keypad_pin_lock_controller.sv
